>>> rtl/soc_pkg.sv
// ----------------------------------------------------------------------------
// soc_pkg
// Types and constants shared by the subsequence occurrence counter files.
// ----------------------------------------------------------------------------
`default_nettype none

package soc_pkg;

  localparam int SYM_BITS = 8;
  localparam int OCC_BITS = 64;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]          command;
    logic [SYM_BITS-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [OCC_BITS-1:0] occurrences;
    logic                saturated;
    logic                pattern_overflow;
  } out_item_t;

  // Row-wide control broadcast to every cell
  typedef struct packed {
    logic                start;
    logic                shift;
    logic                text;
    logic [SYM_BITS-1:0] symbol;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/soc_cell.sv
// ----------------------------------------------------------------------------
// soc_cell
// One pattern position: stores its symbol, a valid bit and a saturating
// count. Appends shift cells one place down the row; text symbols add the
// lower neighbour's count where the symbol matches.
// ----------------------------------------------------------------------------
`default_nettype none

module soc_cell
  import soc_pkg::*;
#(
  parameter int COUNT_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic                  prev_valid,
  input  wire logic [SYM_BITS-1:0]   prev_sym,
  input  wire logic [COUNT_BITS-1:0] prev_count,
  input  wire logic                  lower_valid,
  input  wire logic [COUNT_BITS-1:0] lower_count,
  output logic                       valid,
  output logic [SYM_BITS-1:0]        sym,
  output logic [COUNT_BITS-1:0]      count,
  output logic                       sat_hit
);

  logic                  valid_r;
  logic [SYM_BITS-1:0]   sym_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] lower_eff;
  logic [COUNT_BITS:0]   sum;
  logic                  hit;

  always_comb begin
    // Past the end of the pattern the empty-prefix count of one applies
    lower_eff = lower_valid ? lower_count : COUNT_BITS'(1);
    sum       = {1'b0, count_r} + {1'b0, lower_eff};
    hit       = ctrl.text && valid_r && (sym_r == ctrl.symbol);
    sat_hit   = hit && sum[COUNT_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.start) begin
      valid_r <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      sym_r   <= prev_sym;
      count_r <= prev_count;
    end else if (hit) begin
      count_r <= sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    end
  end

  assign valid = valid_r;
  assign sym   = sym_r;
  assign count = count_r;

endmodule

`default_nettype wire

>>> rtl/subsequence_occurrence_counter_top.sv
// Reports: a report transaction shows its result in the cycle after acceptance.
// Throughput: one transaction per cycle of any command; all cells of the row
// update in the same cycle, and input stalls only while a result waits.
// Reset: synchronous active-low rst_n clears the pattern, both flags and the
// output valid flag at once; a start command does the same to the row.
// ----------------------------------------------------------------------------
// subsequence_occurrence_counter_top
// Counts subsequence occurrences of a loaded pattern in a streamed text
// with a row of cells; the newest pattern symbol sits in cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module subsequence_occurrence_counter_top
  import soc_pkg::*;
#(
  parameter int MAX_PATTERN = 64,
  parameter int COUNT_BITS  = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  cell_ctrl_t            ctrl;
  logic                  accept;
  logic                  full;
  logic                  do_append;
  logic                  do_report;
  logic                  sat_r, sat_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r;

  logic [MAX_PATTERN-1:0] valid_w;
  logic [MAX_PATTERN-1:0] sat_w;
  logic [SYM_BITS-1:0]    sym_w   [MAX_PATTERN];
  logic [COUNT_BITS-1:0]  count_w [MAX_PATTERN];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = valid_w[MAX_PATTERN-1];

  always_comb begin
    ctrl        = '0;
    ctrl.symbol = in_data.symbol;
    do_append   = 1'b0;
    do_report   = 1'b0;
    if (accept) begin
      case (in_data.command)
        CMD_START:  ctrl.start = 1'b1;
        CMD_APPEND: do_append  = 1'b1;
        CMD_TEXT:   ctrl.text  = 1'b1;
        CMD_REPORT: do_report  = 1'b1;
        default:    do_report  = 1'b0;
      endcase
    end
    // Drop the symbol when the row is full
    ctrl.shift = do_append && !full;
  end

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic                  pv;
      logic [SYM_BITS-1:0]   ps;
      logic [COUNT_BITS-1:0] pc;
      logic                  lv;
      logic [COUNT_BITS-1:0] lc;

      if (k == 0) begin : g_head
        assign pv = 1'b1;
        assign ps = in_data.symbol;
        assign pc = '0;
      end else begin : g_body
        assign pv = valid_w[k-1];
        assign ps = sym_w[k-1];
        assign pc = count_w[k-1];
      end

      if (k == MAX_PATTERN - 1) begin : g_tail
        assign lv = 1'b0;
        assign lc = '0;
      end else begin : g_link
        assign lv = valid_w[k+1];
        assign lc = count_w[k+1];
      end

      soc_cell #(
        .COUNT_BITS (COUNT_BITS)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .prev_valid  (pv),
        .prev_sym    (ps),
        .prev_count  (pc),
        .lower_valid (lv),
        .lower_count (lc),
        .valid       (valid_w[k]),
        .sym         (sym_w[k]),
        .count       (count_w[k]),
        .sat_hit     (sat_w[k])
      );
    end
  endgenerate

  always_comb begin
    sat_nxt = sat_r || (|sat_w);
    ovf_nxt = ovf_r || (do_append && full);
    if (ctrl.start) begin
      sat_nxt = 1'b0;
      ovf_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_report) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sat_r       <= sat_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Cell 0 holds the count for the whole pattern; an empty pattern counts one
  always_ff @(posedge clk) begin
    if (do_report) begin
      out_data_r.occurrences      <= valid_w[0] ? OCC_BITS'(count_w[0]) : OCC_BITS'(1);
      out_data_r.saturated        <= sat_r;
      out_data_r.pattern_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/soc_checker.sv
// ----------------------------------------------------------------------------
// soc_checker
// Port-level checks on the subsequence occurrence counter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module soc_checker
  import soc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input stalls exactly while a result waits untaken
  a_ready_map: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // Report straight after start gives one with both flags clear
  a_start_report: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == CMD_START) ##1
    (in_valid && in_ready && in_data.command == CMD_REPORT) |=>
    out_valid && out_data.occurrences == 64'd1 && !out_data.saturated &&
    !out_data.pattern_overflow)
    else $error("bad report after start");

  // A report transaction always produces a result next cycle
  a_report_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == CMD_REPORT |=> out_valid)
    else $error("report transaction gave no result");

endmodule

bind subsequence_occurrence_counter_top soc_checker u_soc_checker (.*);

`default_nettype wire
